/* hw/rtl/sist_pkg.sv */
// Shared definitions for the socket id slot table.
// Holds the command codes, default sizing and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps

package sist_pkg;

	// default number of slots
	localparam int unsigned SLOT_COUNT_DEF = 4;

	// width of the reported used count
	localparam int unsigned USED_W = 3;

	// largest value the used count field can carry
	localparam logic [USED_W-1:0] USED_MAX = '1;

	// command codes carried on the cmd field
	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_full;
	} dp_status_t;

endpackage

/* hw/rtl/sist_ctrl.sv */
// Sequencer for the socket id slot table.
// Captures one command word, then executes it once the result register is free.
// Depends on sist_pkg.
`timescale 1ns / 1ps

module sist_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 out_stall,
	input  sist_pkg::dp_status_t status,
	output sist_pkg::dp_cmd_t    ctrl
);
	import sist_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_free;

	// result register can take a new word this cycle
	assign out_free = !status.out_full || !out_stall;

	// decode commands to the datapath
	assign in_stall     = (state_q != ST_IDLE);
	assign ctrl.capture = (state_q == ST_IDLE) && in_valid;
	assign ctrl.execute = (state_q == ST_EXEC) && out_free;

	// advance the sequence
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

/* hw/rtl/sist_dp.sv */
// Datapath for the socket id slot table: slot registers, parallel compare,
// lowest-slot pick, used count and the result register.
// Depends on sist_pkg.
`timescale 1ns / 1ps

module sist_dp #(
	parameter int unsigned SLOT_COUNT = sist_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sist_pkg::dp_cmd_t           ctrl,
	output sist_pkg::dp_status_t        status,
	input  logic [1:0]                  cmd,
	input  logic [7:0]                  socket_id,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [sist_pkg::USED_W-1:0] used_count,
	output logic                        has_free
);
	import sist_pkg::*;

	localparam int unsigned CW  = $clog2(SLOT_COUNT + 1);
	localparam int unsigned CWX = (CW > USED_W) ? CW : USED_W;

	cmd_t                  cmd_q;
	logic [7:0]            id_q;
	logic [SLOT_COUNT-1:0] in_use_q;
	logic [7:0]            socket_q [SLOT_COUNT];
	logic [CW-1:0]         count_q;

	logic [SLOT_COUNT-1:0] match_vec;
	logic [SLOT_COUNT-1:0] match_oh;
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] free_oh;
	logic [SLOT_COUNT-1:0] in_use_next;
	logic [CW-1:0]         count_next;
	logic [CWX-1:0]        count_ext;
	logic [USED_W-1:0]     count_sat;
	logic                  do_add;
	logic                  do_del;

	logic                  out_valid_q;
	logic                  found_q;
	logic [USED_W-1:0]     used_count_q;
	logic                  has_free_q;

	// hold the captured command word
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd_t'(cmd);
			id_q  <= socket_id;
		end
	end

	// compare every used slot against the id
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match_vec[i] = in_use_q[i] && (socket_q[i] == id_q);
		end
	end

	// isolate the lowest matching and lowest free slot
	assign free_vec = ~in_use_q;
	assign match_oh = match_vec & (~match_vec + SLOT_COUNT'(1));
	assign free_oh  = free_vec & (~free_vec + SLOT_COUNT'(1));

	assign do_add = (cmd_q == CMD_ADD) && (|free_vec);
	assign do_del = (cmd_q == CMD_DELETE) && (|match_vec);

	// work out the slot flags and count after this command
	always_comb begin
		in_use_next = in_use_q;
		count_next  = count_q;
		case (cmd_q)
			CMD_ADD: begin
				if (do_add) begin
					in_use_next = in_use_q | free_oh;
					count_next  = count_q + CW'(1);
				end
			end
			CMD_DELETE: begin
				if (do_del) begin
					in_use_next = in_use_q & ~match_oh;
					count_next  = count_q - CW'(1);
				end
			end
			CMD_SEARCH: begin
				in_use_next = in_use_q;
			end
			CMD_CLEAR: begin
				in_use_next = '0;
				count_next  = '0;
			end
			default: begin
				in_use_next = in_use_q;
			end
		endcase
	end

	// saturate the count to the field width
	assign count_ext = CWX'(count_next);
	assign count_sat = (count_ext > CWX'(USED_MAX)) ? USED_MAX : count_ext[USED_W-1:0];

	// update slot flags and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			count_q  <= '0;
		end else if (ctrl.execute) begin
			in_use_q <= in_use_next;
			count_q  <= count_next;
		end
	end

	// write the id into the slot picked by add
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (ctrl.execute && do_add && free_oh[i]) begin
				socket_q[i] <= id_q;
			end
		end
	end

	// result register valid: set on execute, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.execute) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			found_q      <= (cmd_q == CMD_SEARCH) && (|match_vec);
			used_count_q <= count_sat;
			has_free_q   <= (count_next != CW'(SLOT_COUNT));
		end
	end

	assign status.out_full = out_valid_q;
	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign used_count      = used_count_q;
	assign has_free        = has_free_q;

endmodule

/* hw/rtl/socket_id_slot_table.sv */
// Socket id slot table: a small set of slots holding socket ids with used flags.
// Input channel: in_valid / in_stall with cmd and socket_id. A word is taken at a
// clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with found, used_count and has_free. One
// result word leaves for every command word, in order.
// Commands: add stores the id in the lowest free slot (nothing if full), delete
// frees the lowest used slot holding the id, search reports a hit, clear frees all.
// The controller captures a taken command word and executes it in its execute
// step, which writes the result register; it waits there while an earlier result
// is still stalled. No new command is taken before the last one has executed;
// the command that follows is taken while a result waits.
// When the receiver stalls, the result is held and the next command waits in its
// execute step until the result register is free.
// Reset (arst_n low) frees every slot, clears the count and empties the result
// register; slot ids are not cleared and are never read while free.
// Depends on sist_pkg, sist_ctrl and sist_dp.
`timescale 1ns / 1ps

module socket_id_slot_table #(
	parameter int unsigned SLOT_COUNT = sist_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [7:0]                  socket_id,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [sist_pkg::USED_W-1:0] used_count,
	output logic                        has_free
);
	import sist_pkg::*;

	dp_cmd_t    ctrl;
	dp_status_t status;

	sist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.status    (status),
		.ctrl      (ctrl)
	);

	sist_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.cmd        (cmd),
		.socket_id  (socket_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.used_count (used_count),
		.has_free   (has_free)
	);

`ifndef ASSERT_OFF
	// a taken command word blocks the input until it has executed
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a command is in flight");

	// a search hit needs at least one used slot
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (used_count != '0))
		else $error("hit reported with no used slot");

	// a full table has a nonzero count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_free) |-> (used_count != '0))
		else $error("table full with zero count");

	// an execute never overwrites a result that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.execute && status.out_full) |-> !out_stall)
		else $error("result register overwritten under stall");
`endif

endmodule

/* tb/tb_socket_id_slot_table.sv */
// Self-checking testbench for the socket id slot table.
// Drives command words with random idling and checks every result word
// against a tracker of slot occupancy; depends on sist_pkg and the block.
`timescale 1ns / 1ps

module tb_socket_id_slot_table;
	import sist_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int N_RANDOM = 1600;
	localparam int QUIET_FROM = 1450;
	localparam int PAUSE_AT = 800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	// Tracks slot occupancy and holds the result words still owed by the block.
	class slot_table_tracker;
		typedef struct {
			logic              found;
			logic [USED_W-1:0] used;
			logic              free;
		} reply_t;

		bit          slot_busy[SLOTS];
		logic [7:0]  slot_sock[SLOTS];
		reply_t      owed_replies[$];
		int          mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i] = 1'b0;
				slot_sock[i] = 8'h00;
			end
			mismatches = 0;
		endfunction

		// Apply one accepted command and queue the result word it must produce.
		function void note_command(cmd_t c, logic [7:0] id);
			reply_t r;
			int     hit;
			int     first_free;
			int     n;
			r.found = 1'b0;
			hit = -1;
			first_free = -1;
			n = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_busy[i] && slot_sock[i] == id && hit < 0)
					hit = i;
				if (!slot_busy[i] && first_free < 0)
					first_free = i;
			end
			case (c)
				CMD_ADD: begin
					if (first_free >= 0) begin
						slot_busy[first_free] = 1'b1;
						slot_sock[first_free] = id;
					end
				end
				CMD_DELETE: begin
					if (hit >= 0)
						slot_busy[hit] = 1'b0;
				end
				CMD_SEARCH: begin
					r.found = (hit >= 0);
				end
				default: begin
					for (int i = 0; i < SLOTS; i++)
						slot_busy[i] = 1'b0;
				end
			endcase
			for (int i = 0; i < SLOTS; i++)
				if (slot_busy[i])
					n++;
			r.used = (n > int'(USED_MAX)) ? USED_MAX : USED_W'(n);
			r.free = (n < SLOTS);
			owed_replies.push_back(r);
		endfunction

		// Compare one result word with the oldest owed one.
		function void check_reply(logic f, logic [USED_W-1:0] u, logic h);
			reply_t r;
			if (owed_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with none owed: found=%b used=%0d free=%b",
						$time, f, u, h);
				return;
			end
			r = owed_replies.pop_front();
			if (f !== r.found || u !== r.used || h !== r.free) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected found=%b used=%0d free=%b, got found=%b used=%0d free=%b",
						$time, r.found, r.used, r.free, f, u, h);
			end
		endfunction

		function int owed();
			return owed_replies.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = CMD_SEARCH;
	logic [7:0]        socket_id = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;
	logic [USED_W-1:0] used_count;
	logic              has_free;

	slot_table_tracker tracker = new();
	bit                idle_on = 1'b1;
	int                stall_left = 0;
	int                cycles = 0;
	logic [7:0]        id_pool[6];

	socket_id_slot_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.socket_id  (socket_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.used_count (used_count),
		.has_free   (has_free)
	);

	always #5 clk = ~clk;

	// Bound the run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_socket_id_slot_table: FAIL");
			$finish;
		end
	end

	// Take result words and stall the output in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_reply(found, used_count, has_free);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (idle_on && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	// Offer one command word, hold it until taken, then note it.
	task automatic send_word(input cmd_t c, input logic [7:0] id);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		socket_id <= id;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_command(c, id);
	endtask

	// Mostly ids from a small pool so that hits and duplicates are common.
	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 9) < 7)
			return id_pool[$urandom_range(0, 5)];
		return 8'($urandom());
	endfunction

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 33)
			return CMD_ADD;
		if (r < 62)
			return CMD_DELETE;
		if (r < 93)
			return CMD_SEARCH;
		return CMD_CLEAR;
	endfunction

	initial begin
		id_pool[0] = 8'h00;
		id_pool[1] = 8'hFF;
		for (int i = 2; i < 6; i++)
			id_pool[i] = 8'($urandom());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, fill to full, add when full, missing and stale ids,
		// duplicates, clear.
		send_word(CMD_SEARCH, 8'h00);
		send_word(CMD_DELETE, 8'hFF);
		send_word(CMD_ADD,    8'h00);
		send_word(CMD_ADD,    8'hFF);
		send_word(CMD_ADD,    8'h55);
		send_word(CMD_ADD,    8'hAA);
		send_word(CMD_ADD,    8'h12);
		send_word(CMD_SEARCH, 8'hFF);
		send_word(CMD_SEARCH, 8'h12);
		send_word(CMD_DELETE, 8'h12);
		send_word(CMD_DELETE, 8'h55);
		send_word(CMD_SEARCH, 8'h55);
		send_word(CMD_ADD,    8'h00);
		send_word(CMD_DELETE, 8'h00);
		send_word(CMD_SEARCH, 8'h00);
		send_word(CMD_DELETE, 8'h00);
		send_word(CMD_SEARCH, 8'h00);
		send_word(CMD_CLEAR,  8'hC3);
		send_word(CMD_SEARCH, 8'hFF);
		send_word(CMD_DELETE, 8'hAA);
		send_word(CMD_ADD,    8'h33);
		send_word(CMD_CLEAR,  8'h00);

		// Random commands; hold off once until the block has drained.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				while (tracker.owed() != 0)
					@(posedge clk);
			end
			if (n == QUIET_FROM)
				idle_on = 1'b0;
			send_word(pick_cmd(), pick_id());
		end
		in_valid <= 1'b0;

		// Drain, then allow a few cycles for stray words.
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("tb_socket_id_slot_table: PASS");
		else
			$display("tb_socket_id_slot_table: FAIL");
		$finish;
	end

endmodule
